// ----- rtl/upct_pkg.sv -----
`default_nettype none
package upct_pkg;

   localparam int ANGLE_BITS_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES      = 24;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [2:0] CSR_INV_LAMBDA  = 3'd0;
   localparam logic [2:0] CSR_BIAS_COEF   = 3'd1;
   localparam logic [2:0] CSR_LAMBDA_POW4 = 3'd2;
   localparam logic [2:0] CSR_RANGE_VAR   = 3'd3;
   localparam logic [2:0] CSR_SENSOR_X    = 3'd4;
   localparam logic [2:0] CSR_SENSOR_Y    = 3'd5;

   typedef struct packed {
      logic [15:0] trk_num;
      logic [31:0] frame_no;
      logic [7:0]  source_index;
      logic [23:0] meas_range;
   } meta_type;

   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'd536870912;
         1: v = 32'd316933406;
         2: v = 32'd167458907;
         3: v = 32'd85004756;
         4: v = 32'd42667331;
         5: v = 32'd21354465;
         6: v = 32'd10679838;
         7: v = 32'd5340245;
         8: v = 32'd2670163;
         9: v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // round to nearest, ties away from zero, then shift right
   function automatic logic signed [71:0] rnd(input logic signed [71:0] v, input int sh);
      logic signed [71:0] h;
      logic signed [71:0] a;
      h = 72'sd1 <<< (sh - 1);
      a = v[71] ? (h - 72'sd1) : h;
      return (v + a) >>> sh;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/upct_cordic.sv -----
`default_nettype none
module upct_cordic
   import upct_pkg::*;
#(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic signed [15:0] in_bearing,
   input  wire meta_type           in_meta,
   output logic                    out_valid,
   output logic signed [17:0]      out_cos,
   output logic signed [17:0]      out_sin,
   output meta_type                out_meta
);

   localparam logic [31:0] MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

   logic signed [33:0] x_ff [CORDIC_STAGES+1];
   logic signed [33:0] y_ff [CORDIC_STAGES+1];
   logic signed [33:0] z_ff [CORDIC_STAGES+1];
   logic               f_ff [CORDIC_STAGES+1];
   logic               v_ff [CORDIC_STAGES+1];
   meta_type           m_ff [CORDIC_STAGES+1];

   logic [31:0]        a_in;
   logic               flip_in;
   logic [31:0]        sum_in;

   always_comb begin
      a_in    = {in_bearing, 16'd0} & MASK;
      sum_in  = a_in + 32'h4000_0000;
      flip_in = sum_in[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= 34'sd0;
         z_ff[0] <= 34'(signed'(a_in ^ {flip_in, 31'd0}));
         f_ff[0] <= flip_in;
         m_ff[0] <= in_meta;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [33:0] ATAN = 34'(signed'({1'b0, atan_entry(i) & MASK}));
      logic signed [33:0] x_in, y_in, z_in;
      always_comb begin
         if (!z_ff[i][33]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ATAN;
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (adv) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            f_ff[i+1] <= f_ff[i];
            m_ff[i+1] <= m_ff[i];
         end
      end
   end

   function automatic logic signed [17:0] fin(input logic signed [33:0] v, input logic neg);
      logic signed [71:0] t;
      t = neg ? -72'(v) : 72'(v);
      t = rnd(t, 14);
      if (t > 72'sd65536) begin
         t = 72'sd65536;
      end else if (t < -72'sd65536) begin
         t = -72'sd65536;
      end
      return t[17:0];
   endfunction

   logic signed [17:0] cos_ff, sin_ff;
   logic               ov_ff;
   meta_type           om_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= v_ff[CORDIC_STAGES];
      end
      if (adv) begin
         cos_ff <= fin(x_ff[CORDIC_STAGES], f_ff[CORDIC_STAGES]);
         sin_ff <= fin(y_ff[CORDIC_STAGES], f_ff[CORDIC_STAGES]);
         om_ff  <= m_ff[CORDIC_STAGES];
      end
   end

   assign out_valid = ov_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_meta  = om_ff;

endmodule
`default_nettype wire

// ----- rtl/unbiased_polar_to_cartesian_track_init_top.sv -----
`default_nettype none
// channel   | ports                      | payload
// req       | req_tvalid/tready/tdata    | range, bearing, frame time, index, id base
// rsp       | rsp_tvalid/tready/tdata    | track id, time, index, position, covariance
// csr       | csr_we/addr/wdata          | bias factors, range variance, sensor offset
// One item per cycle while rsp is not stalled. The pipeline is the CORDIC
// stage chain followed by the split multiply stages. Synchronous reset empties
// the pipeline and loads register defaults. A stalled rsp freezes every stage.
module unbiased_polar_to_cartesian_track_init_top
   import upct_pkg::*;
#(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // meas_range, meas_bearing, frame_time, meas_index, id_base
   input  wire logic [95:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // track id, frame time, source_index, pos_x, pos_y, var_x, var_y, cov_xy
   output logic [287:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [47:0]  csr_wdata
);

   logic [17:0]        inv_lambda_ff;
   logic signed [17:0] bias_coef_ff;
   logic [16:0]        lambda_pow4_ff;
   logic [47:0]        range_var_ff;
   logic signed [31:0] sensor_x_ff, sensor_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_lambda_ff  <= 18'd65536;
         bias_coef_ff   <= -18'sd65536;
         lambda_pow4_ff <= 17'd65536;
         range_var_ff   <= 48'd0;
         sensor_x_ff    <= 32'sd0;
         sensor_y_ff    <= 32'sd0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_INV_LAMBDA:  inv_lambda_ff  <= csr_wdata[17:0];
            CSR_BIAS_COEF:   bias_coef_ff   <= csr_wdata[17:0];
            CSR_LAMBDA_POW4: lambda_pow4_ff <= csr_wdata[16:0];
            CSR_RANGE_VAR:   range_var_ff   <= csr_wdata;
            CSR_SENSOR_X:    sensor_x_ff    <= csr_wdata[31:0];
            CSR_SENSOR_Y:    sensor_y_ff    <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic     adv;
   logic     v_ff [1:7];
   meta_type m_ff [1:7];

   assign adv        = !v_ff[7] || rsp_tready;
   assign req_tready = adv;

   meta_type           meta_in;
   logic               v0;
   logic signed [17:0] c0, s0;
   meta_type           m0;

   always_comb begin
      meta_in.meas_range   = req_tdata[23:0];
      meta_in.frame_no     = req_tdata[71:40];
      meta_in.source_index = req_tdata[79:72];
      meta_in.trk_num      = req_tdata[95:80] + {8'd0, req_tdata[79:72]} + 16'd1;
   end

   upct_cordic #(
      .ANGLE_BITS    (ANGLE_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_tvalid),
      .in_bearing (req_tdata[39:24]),
      .in_meta    (meta_in),
      .out_valid  (v0),
      .out_cos    (c0),
      .out_sin    (s0),
      .out_meta   (m0)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 7; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[1] <= v0;
         for (int k = 2; k <= 7; k++) v_ff[k] <= v_ff[k-1];
      end
      if (adv) begin
         m_ff[1] <= m0;
         for (int k = 2; k <= 7; k++) m_ff[k] <= m_ff[k-1];
      end
   end

   // stage 1: products of r, cos, sin
   logic signed [42:0] rc1_ff [2], rc1_in [2];
   logic signed [35:0] cc1_ff, ss1_ff, cs1_ff, cc1_in, ss1_in, cs1_in;
   logic [47:0]        r21_ff, r21_in;

   always_comb begin
      rc1_in[0] = $signed({1'b0, m0.meas_range}) * c0;
      rc1_in[1] = $signed({1'b0, m0.meas_range}) * s0;
      cc1_in    = c0 * c0;
      ss1_in    = s0 * s0;
      cs1_in    = c0 * s0;
      r21_in    = 48'(m0.meas_range) * 48'(m0.meas_range);
   end

   // stage 2: position partials, squared and double-angle trig terms, range sum
   logic signed [40:0] pl2_ff [2], ph2_ff [2], pl2_in [2], ph2_in [2];
   logic signed [17:0] q2_ff [3], q2_in [3];
   logic signed [17:0] cos2_ff, sin2_ff, cos2_in, sin2_in;
   logic [47:0]        r22_ff;
   logic [48:0]        sumr2_ff, sumr2_in;

   always_comb begin
      logic signed [71:0] t;
      for (int k = 0; k < 2; k++) begin
         pl2_in[k] = $signed({1'b0, rc1_ff[k][20:0]}) * $signed({1'b0, inv_lambda_ff});
         ph2_in[k] = $signed(rc1_ff[k][42:21]) * $signed({1'b0, inv_lambda_ff});
      end
      t = rnd(72'(cc1_ff), 16);
      q2_in[0] = t[17:0];
      t = rnd(72'(ss1_ff), 16);
      q2_in[1] = t[17:0];
      t = rnd(72'(cs1_ff), 16);
      q2_in[2] = t[17:0];
      t = rnd(72'(cc1_ff) - 72'(ss1_ff), 16);
      cos2_in = t[17:0];
      t = rnd(72'(cs1_ff) <<< 1, 16);
      sin2_in = t[17:0];
      sumr2_in = 49'(r21_ff) + 49'(range_var_ff);
   end

   // stage 3: round position, r^2 partials, lambda^4 terms
   logic signed [31:0] p3_ff [2], p3_in [2];
   logic signed [42:0] tl3_ff [3], th3_ff [3], tl3_in [3], th3_in [3];
   logic signed [18:0] l4c3_ff, l4s3_ff, l4c3_in, l4s3_in;
   logic [48:0]        sumr3_ff;

   always_comb begin
      logic signed [71:0] t;
      for (int k = 0; k < 2; k++) begin
         t = rnd(72'(pl2_ff[k]) + (72'(ph2_ff[k]) <<< 21), 32);
         p3_in[k] = t[31:0];
      end
      for (int k = 0; k < 3; k++) begin
         tl3_in[k] = $signed({1'b0, r22_ff[23:0]}) * q2_ff[k];
         th3_in[k] = $signed({1'b0, r22_ff[47:24]}) * q2_ff[k];
      end
      t = rnd(72'($signed({1'b0, lambda_pow4_ff})) * 72'(cos2_ff), 16);
      l4c3_in = t[18:0];
      t = rnd(72'($signed({1'b0, lambda_pow4_ff})) * 72'(sin2_ff), 16);
      l4s3_in = t[18:0];
   end

   // stage 4: bias base, sensor offset with saturation, half-term factors
   logic signed [49:0] t14_ff [3], t14_in [3];
   logic signed [31:0] pos4_ff [2], pos4_in [2];
   logic signed [19:0] f4_ff [3], f4_in [3];
   logic [48:0]        sumr4_ff;

   always_comb begin
      logic signed [71:0] t;
      for (int k = 0; k < 3; k++) begin
         t = rnd(72'(tl3_ff[k]) + (72'(th3_ff[k]) <<< 24), 16);
         t14_in[k] = t[49:0];
      end
      for (int k = 0; k < 2; k++) begin
         t = 72'(p3_ff[k]) + ((k == 0) ? 72'(sensor_x_ff) : 72'(sensor_y_ff));
         if (t > 72'sd2147483647) begin
            pos4_in[k] = 32'sh7FFF_FFFF;
         end else if (t < -72'sd2147483648) begin
            pos4_in[k] = 32'sh8000_0000;
         end else begin
            pos4_in[k] = t[31:0];
         end
      end
      f4_in[0] = 20'sd65536 + 20'(l4c3_ff);
      f4_in[1] = 20'sd65536 - 20'(l4c3_ff);
      f4_in[2] = 20'(l4s3_ff);
   end

   // stage 5: partial products of the bias and half terms
   logic signed [43:0] bl5_ff [3], bh5_ff [3], bl5_in [3], bh5_in [3];
   logic signed [45:0] hl5_ff [3], hh5_ff [3], hl5_in [3], hh5_in [3];
   logic signed [31:0] pos5_ff [2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         bl5_in[k] = 44'($signed({1'b0, t14_ff[k][24:0]})) * 44'(bias_coef_ff);
         bh5_in[k] = 44'($signed(t14_ff[k][49:25])) * 44'(bias_coef_ff);
         hl5_in[k] = $signed({1'b0, sumr4_ff[24:0]}) * f4_ff[k];
         hh5_in[k] = 46'($signed({1'b0, sumr4_ff[48:25]})) * 46'(f4_ff[k]);
      end
   end

   // stage 6: assemble and round both terms
   logic signed [53:0] b6_ff [3], h6_ff [3], b6_in [3], h6_in [3];
   logic signed [31:0] pos6_ff [2];

   always_comb begin
      logic signed [71:0] t;
      for (int k = 0; k < 3; k++) begin
         t = rnd(72'(bl5_ff[k]) + (72'(bh5_ff[k]) <<< 25), 16);
         b6_in[k] = t[53:0];
         t = rnd(72'(hl5_ff[k]) + (72'(hh5_ff[k]) <<< 25), 17);
         h6_in[k] = t[53:0];
      end
   end

   // stage 7: sum and saturate into the output register
   logic [55:0]        var7_ff [2], var7_in [2];
   logic signed [55:0] cov7_ff, cov7_in;
   logic signed [31:0] pos7_ff [2];

   always_comb begin
      logic signed [71:0] t;
      for (int k = 0; k < 2; k++) begin
         t = 72'(b6_ff[k]) + 72'(h6_ff[k]);
         if (t < 72'sd0) begin
            var7_in[k] = 56'd0;
         end else if (t > 72'sd72057594037927935) begin
            var7_in[k] = {56{1'b1}};
         end else begin
            var7_in[k] = t[55:0];
         end
      end
      t = 72'(b6_ff[2]) + 72'(h6_ff[2]);
      if (t > 72'sd36028797018963967) begin
         cov7_in = 56'sh7F_FFFF_FFFF_FFFF;
      end else if (t < -72'sd36028797018963968) begin
         cov7_in = 56'sh80_0000_0000_0000;
      end else begin
         cov7_in = t[55:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rc1_ff   <= rc1_in;
         cc1_ff   <= cc1_in;
         ss1_ff   <= ss1_in;
         cs1_ff   <= cs1_in;
         r21_ff   <= r21_in;
         pl2_ff   <= pl2_in;
         ph2_ff   <= ph2_in;
         q2_ff    <= q2_in;
         cos2_ff  <= cos2_in;
         sin2_ff  <= sin2_in;
         r22_ff   <= r21_ff;
         sumr2_ff <= sumr2_in;
         p3_ff    <= p3_in;
         tl3_ff   <= tl3_in;
         th3_ff   <= th3_in;
         l4c3_ff  <= l4c3_in;
         l4s3_ff  <= l4s3_in;
         sumr3_ff <= sumr2_ff;
         t14_ff   <= t14_in;
         pos4_ff  <= pos4_in;
         f4_ff    <= f4_in;
         sumr4_ff <= sumr3_ff;
         bl5_ff   <= bl5_in;
         bh5_ff   <= bh5_in;
         hl5_ff   <= hl5_in;
         hh5_ff   <= hh5_in;
         pos5_ff  <= pos4_ff;
         b6_ff    <= b6_in;
         h6_ff    <= h6_in;
         pos6_ff  <= pos5_ff;
         var7_ff  <= var7_in;
         cov7_ff  <= cov7_in;
         pos7_ff  <= pos6_ff;
      end
   end

   assign rsp_tvalid = v_ff[7];
   assign rsp_tdata  = {cov7_ff, var7_ff[1], var7_ff[0], pos7_ff[1], pos7_ff[0],
                        m_ff[7].source_index, m_ff[7].frame_no, m_ff[7].trk_num};

endmodule
`default_nettype wire
